// ===== rtl/core/lsp_pkg.sv =====
// Package for the laser scan to points filter: register indexes, step codes,
// microcode word layout, program table and the quarter-wave sine generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsp_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int RANGE_BITS_DEF      = 16;

    localparam int CFG_W = 3;
    localparam logic [CFG_W-1:0] CFG_RANGE_MIN   = 3'd0;
    localparam logic [CFG_W-1:0] CFG_RANGE_MAX   = 3'd1;
    localparam logic [CFG_W-1:0] CFG_ANGLE_START = 3'd2;
    localparam logic [CFG_W-1:0] CFG_ANGLE_END   = 3'd3;
    localparam logic [CFG_W-1:0] CFG_ANGLE_STEP  = 3'd4;
    localparam logic [CFG_W-1:0] CFG_TRUNCATE    = 3'd5;
    localparam logic [CFG_W-1:0] CFG_GAP_LIMIT   = 3'd6;

    localparam logic [15:0] RANGE_MIN_RST   = 16'd0;
    localparam logic [15:0] RANGE_MAX_RST   = 16'd10000;
    localparam logic [15:0] ANGLE_START_RST = 16'hC000;
    localparam logic [15:0] ANGLE_END_RST   = 16'h4000;
    localparam logic [13:0] ANGLE_STEP_RST  = 14'd182;
    localparam logic [15:0] GAP_LIMIT_RST   = 16'd100;
    localparam int          TURN_TRUNC      = 2731;
    localparam logic [15:0] OUT_LIMIT       = 16'hFFFF;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_WAIT    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_TEST    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MUL_COS = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MUL_SIN = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SCALE_Y = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DIFF    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SQ_X    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_SQ_Y    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_SQ_GAP  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_DECIDE  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_ADVANCE = 4'd10;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ROM,
        MUL_DX,
        MUL_DY,
        MUL_GAP
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_REJECT,
        COND_NO_PREV,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic              accept;
        logic              rom_sin;
        mul_sel_t          mul_sel;
        logic              scale_x;
        logic              scale_y;
        logic              diff;
        acc_op_t           acc_op;
        logic              decide;
        logic              advance;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w.accept  = 1'b0;
        w.rom_sin = 1'b0;
        w.mul_sel = MUL_NONE;
        w.scale_x = 1'b0;
        w.scale_y = 1'b0;
        w.diff    = 1'b0;
        w.acc_op  = ACC_HOLD;
        w.decide  = 1'b0;
        w.advance = 1'b0;
        w.cond    = COND_NEVER;
        w.target  = STEP_WAIT;
        case (step)
            STEP_WAIT:
            begin
                w.accept = 1'b1;
                w.cond   = COND_NO_INPUT;
                w.target = STEP_WAIT;
            end
            STEP_TEST:
            begin
                w.cond   = COND_REJECT;
                w.target = STEP_ADVANCE;
            end
            STEP_MUL_COS:
            begin
                w.mul_sel = MUL_ROM;
                w.rom_sin = 1'b1;
            end
            STEP_MUL_SIN:
            begin
                w.mul_sel = MUL_ROM;
                w.scale_x = 1'b1;
            end
            STEP_SCALE_Y:
            begin
                w.scale_y = 1'b1;
                w.cond    = COND_NO_PREV;
                w.target  = STEP_DECIDE;
            end
            STEP_DIFF:
            begin
                w.diff = 1'b1;
            end
            STEP_SQ_X:
            begin
                w.mul_sel = MUL_DX;
            end
            STEP_SQ_Y:
            begin
                w.mul_sel = MUL_DY;
                w.acc_op  = ACC_LOAD;
            end
            STEP_SQ_GAP:
            begin
                w.mul_sel = MUL_GAP;
                w.acc_op  = ACC_ADD;
            end
            STEP_DECIDE:
            begin
                w.decide = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = STEP_DECIDE;
            end
            STEP_ADVANCE:
            begin
                w.advance = 1'b1;
                w.cond    = COND_ALWAYS;
                w.target  = STEP_WAIT;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

    // Q15 quarter-wave entry from a Q30 Taylor series up to the x^17 term.
    function automatic logic [15:0] qsine_entry(input int unsigned idx,
                                                input int unsigned tbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned q;
        x    = (PI_Q30 * 64'd2 * longint'(idx)) >> tbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
        term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
        q = (sum + 64'd16384) >> 15;
        if (q > 64'd32768)
        begin
            q = 64'd32768;
        end
        return q[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/laser_scan_to_points_filter.sv =====
// Laser scan to points filter: microcoded sequencer with one shared multiplier,
// registered quarter-wave sine ROM and an output register.
// Depends on lsp_pkg (step codes, microcode table, sine generator).
// A kept point raises m_tvalid from the decide step; when no previous point is held in
// the scan, the difference and square steps are skipped. A rejected sample (every
// first-of-scan beam) goes from the window test straight to the angle advance. No new
// sample is taken until the last is through; decide waits while a held point sees m_tready low.
// Reset is asynchronous, active low: configuration registers take their defaults,
// the beam angle takes -16384 and no previous point is held.
`timescale 1ns / 1ps
`default_nettype none

module laser_scan_to_points_filter
    import lsp_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int RANGE_BITS      = RANGE_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_index,
    input  wire logic [15:0]      cfg_data,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [15:0]      s_tdata,   // [15:0] range_mm
    input  wire logic             s_tuser,   // [0] first_of_scan
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [39:0]           m_tdata    // [16:0] point_x, [33:17] point_y
);

    localparam int RW   = (RANGE_BITS < 16) ? RANGE_BITS : 16;
    localparam int MA   = (RW > 18) ? RW : 18;
    localparam int PW   = MA + 18;
    localparam int AW   = SINE_TABLE_BITS - 1;
    localparam int QLEN = (1 << (SINE_TABLE_BITS - 2)) + 1;
    localparam logic [SINE_TABLE_BITS-1:0] QTR_IDX = SINE_TABLE_BITS'(1 << (SINE_TABLE_BITS - 2));
    localparam logic [AW-1:0] QTR_ADDR = AW'(1 << (SINE_TABLE_BITS - 2));

    // configuration
    logic [RW-1:0]        range_min_reg;
    logic [RW-1:0]        range_max_reg;
    logic signed [15:0]   angle_start_reg;
    logic signed [15:0]   angle_end_reg;
    logic signed [13:0]   angle_step_reg;
    logic                 truncate_reg;
    logic [15:0]          gap_limit_reg;

    // sequencer and state
    logic [STEP_W-1:0]    pc_reg, pc_next;
    ucode_t               uw;
    logic                 jump;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_busy;
    logic                 have_prev_reg;
    logic signed [31:0]   angle_reg;
    logic signed [16:0]   prev_x_reg, prev_y_reg;

    // datapath
    logic [RW-1:0]        range_reg;
    logic [15:0]          qtab [QLEN];
    logic [AW-1:0]        rom_addr;
    logic                 rom_neg;
    logic [15:0]          rom_q_reg;
    logic                 rom_neg_reg;
    logic [MA-1:0]        mul_a;
    logic [17:0]          mul_b;
    logic [PW-1:0]        mul_p;
    logic [PW-1:0]        prod_reg;
    logic                 prod_neg_reg;
    logic [PW:0]          acc_reg;
    logic signed [16:0]   px_reg, py_reg;
    logic [17:0]          adx_reg, ady_reg;
    logic signed [16:0]   out_x_reg, out_y_reg;

    logic [PW-1:0]        rnd_sum;
    logic [PW-16:0]       rnd;
    logic [15:0]          sat_mag;
    logic signed [16:0]   scaled;
    logic signed [32:0]   win_lo, win_hi, angle_ext, angle_sum;
    logic                 window_ok;
    logic [SINE_TABLE_BITS-1:0] idx_base, idx_j;
    logic signed [17:0]   dx, dy;
    logic                 keep;
    logic                 decide_fire;
    logic                 in_fire;

    for (genvar g = 0; g < QLEN; g++)
    begin : g_qtab
        assign qtab[g] = qsine_entry(g, SINE_TABLE_BITS);
    end

    assign uw          = ucode_rom(pc_reg);
    assign s_tready    = uw.accept;
    assign in_fire     = s_tvalid && uw.accept;
    assign out_busy    = out_valid_reg && !m_tready;
    assign decide_fire = uw.decide && !out_busy;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = {6'd0, out_y_reg, out_x_reg};
    assign mul_p       = mul_a * mul_b;

    always_comb
    begin
        win_lo    = 33'(angle_start_reg) + (truncate_reg ? 33'(TURN_TRUNC) : 33'sd0);
        win_hi    = 33'(angle_end_reg) - (truncate_reg ? 33'(TURN_TRUNC) : 33'sd0);
        angle_ext = 33'(angle_reg);
        window_ok = (range_reg >= range_min_reg) && (range_reg <= range_max_reg) &&
                    (angle_ext > win_lo) && (angle_ext < win_hi);
        angle_sum = angle_ext + 33'(angle_step_reg);
    end

    // table index: cos reads a quarter turn ahead, mirrored and signed by quadrant
    always_comb
    begin
        idx_base = angle_reg[15 -: SINE_TABLE_BITS];
        idx_j    = uw.rom_sin ? idx_base : idx_base + QTR_IDX;
        rom_addr = idx_j[SINE_TABLE_BITS-2] ?
                   QTR_ADDR - {1'b0, idx_j[SINE_TABLE_BITS-3:0]} :
                   {1'b0, idx_j[SINE_TABLE_BITS-3:0]};
        rom_neg  = idx_j[SINE_TABLE_BITS-1];
    end

    always_comb
    begin
        rnd_sum = prod_reg + PW'(16384);
        rnd     = rnd_sum[PW-1:15];
        sat_mag = (rnd > (PW-15)'(OUT_LIMIT)) ? OUT_LIMIT : rnd[15:0];
        scaled  = prod_neg_reg ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag});
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (uw.mul_sel)
            MUL_ROM:
            begin
                mul_a = MA'(range_reg);
                mul_b = 18'(rom_q_reg);
            end
            MUL_DX:
            begin
                mul_a = MA'(adx_reg);
                mul_b = adx_reg;
            end
            MUL_DY:
            begin
                mul_a = MA'(ady_reg);
                mul_b = ady_reg;
            end
            MUL_GAP:
            begin
                mul_a = MA'(gap_limit_reg);
                mul_b = 18'(gap_limit_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        dx   = 18'(px_reg) - 18'(prev_x_reg);
        dy   = 18'(py_reg) - 18'(prev_y_reg);
        keep = !have_prev_reg || (acc_reg <= {1'b0, prod_reg});
    end

    always_comb
    begin
        case (uw.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_INPUT: jump = !s_tvalid;
            COND_REJECT:   jump = !window_ok;
            COND_NO_PREV:  jump = !have_prev_reg;
            COND_OUT_BUSY: jump = out_busy;
            default:       jump = 1'b1;
        endcase
        pc_next = jump ? uw.target : pc_reg + 1'b1;

        out_valid_next = out_valid_reg;
        if (decide_fire && keep)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg   <= RW'(RANGE_MIN_RST);
            range_max_reg   <= RW'(RANGE_MAX_RST);
            angle_start_reg <= ANGLE_START_RST;
            angle_end_reg   <= ANGLE_END_RST;
            angle_step_reg  <= ANGLE_STEP_RST;
            truncate_reg    <= 1'b0;
            gap_limit_reg   <= GAP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RANGE_MIN:   range_min_reg   <= cfg_data[RW-1:0];
                CFG_RANGE_MAX:   range_max_reg   <= cfg_data[RW-1:0];
                CFG_ANGLE_START: angle_start_reg <= cfg_data;
                CFG_ANGLE_END:   angle_end_reg   <= cfg_data;
                CFG_ANGLE_STEP:  angle_step_reg  <= cfg_data[13:0];
                CFG_TRUNCATE:    truncate_reg    <= cfg_data[0];
                CFG_GAP_LIMIT:   gap_limit_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_WAIT;
            out_valid_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            angle_reg     <= 32'(signed'(ANGLE_START_RST));
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (in_fire && s_tuser)
            begin
                angle_reg     <= 32'(angle_start_reg);
                have_prev_reg <= 1'b0;
            end
            if (uw.advance)
            begin
                if (angle_sum > 33'sd2147483647)
                begin
                    angle_reg <= 32'sh7FFFFFFF;
                end
                else if (angle_sum < -33'sd2147483648)
                begin
                    angle_reg <= 32'sh80000000;
                end
                else
                begin
                    angle_reg <= angle_sum[31:0];
                end
            end
            if (decide_fire)
            begin
                prev_x_reg    <= px_reg;
                prev_y_reg    <= py_reg;
                have_prev_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg   <= qtab[rom_addr];
        rom_neg_reg <= rom_neg;
        if (in_fire)
        begin
            range_reg <= s_tdata[RW-1:0];
        end
        if (uw.mul_sel != MUL_NONE)
        begin
            prod_reg     <= mul_p;
            prod_neg_reg <= rom_neg_reg;
        end
        if (uw.scale_x)
        begin
            px_reg <= scaled;
        end
        if (uw.scale_y)
        begin
            py_reg <= scaled;
        end
        if (uw.diff)
        begin
            adx_reg <= dx[17] ? 18'(-dx) : 18'(dx);
            ady_reg <= dy[17] ? 18'(-dy) : 18'(dy);
        end
        case (uw.acc_op)
            ACC_LOAD: acc_reg <= {1'b0, prod_reg};
            ACC_ADD:  acc_reg <= acc_reg + {1'b0, prod_reg};
            default:  ;
        endcase
        if (decide_fire && keep)
        begin
            out_x_reg <= px_reg;
            out_y_reg <= py_reg;
        end
    end

    a_accept_to_test: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (pc_reg == STEP_TEST))
        else $error("sample transaction not followed by window test");

    a_out_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(pc_reg) == STEP_DECIDE))
        else $error("output raised outside decide step");

    a_prev_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(have_prev_reg) |-> ($past(pc_reg) == STEP_DECIDE))
        else $error("previous point set outside decide step");

    a_decide_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_DECIDE && out_busy) |=> (pc_reg == STEP_DECIDE))
        else $error("decide step left while output busy");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg != STEP_WAIT) |-> !s_tready)
        else $error("input ready during sample processing");

endmodule

`default_nettype wire

// ===== bench/tb_laser_scan_to_points_filter.sv =====
// Testbench for laser_scan_to_points_filter: directed and random range samples on
// the stream ports, points predicted in the bench and checked per transaction.
// Depends on lsp_pkg (register indexes) and the filter RTL.
`timescale 1ns / 1ps

module tb_laser_scan_to_points_filter;
    import lsp_pkg::*;

    localparam int SINE_BITS     = 10;
    localparam int QUARTER       = 1 << (SINE_BITS - 2);
    localparam int TRIM_UNITS    = 2731;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 1000;
    localparam longint unsigned PI_Q30_VAL = 64'd3373259426;
    localparam longint BEAM_POS_HI = 2147483647;
    localparam longint BEAM_POS_LO = -BEAM_POS_HI - 1;
    localparam logic [CFG_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
    } point_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_index;
    logic [15:0]      cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [15:0]      s_tdata;   // [15:0] range_mm
    logic             s_tuser;   // [0] first_of_scan
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [39:0]      m_tdata;   // [16:0] point_x, [33:17] point_y

    // predicted block state
    logic [15:0]        lim_lo     = 16'd0;
    logic [15:0]        lim_hi     = 16'd10000;
    logic signed [15:0] win_start  = -16'sd16384;
    logic signed [15:0] win_end    = 16'sd16384;
    logic signed [13:0] beam_step  = 14'sd182;
    logic               trim_on    = 1'b0;
    logic [15:0]        gap_mm     = 16'd100;
    longint             beam_pos;
    logic signed [16:0] last_x     = '0;
    logic signed [16:0] last_y     = '0;
    bit                 last_valid = 1'b0;
    int                 quarter_q15 [0:QUARTER];

    point_t pending_points [$];
    int     mismatch_count = 0;
    int     ready_hold     = 0;
    int     phase_items    = 0;
    bit     gaps_on        = 1'b1;
    bit     stalls_on      = 1'b1;

    laser_scan_to_points_filter uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int quarter_wave_q15(input int unsigned i);
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned div;
        longint unsigned q;
        int k;
        ang  = (PI_Q30_VAL * 64'd2 * i) >> SINE_BITS;
        ang2 = (ang * ang) >> 30;
        term = ang;
        acc  = ang;
        for (k = 1; k <= 8; k++)
        begin
            div  = 2 * k * (2 * k + 1);
            term = ((term * ang2) >> 30) / div;
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        q = (acc + 64'd16384) >> 15;
        if (q > 64'd32768)
            q = 64'd32768;
        return int'(q);
    endfunction

    function automatic int sine_q15(input logic [SINE_BITS-1:0] j);
        int quad;
        int r;
        int v;
        quad = int'(j) / QUARTER;
        r    = int'(j) % QUARTER;
        v    = (quad % 2 == 1) ? quarter_q15[QUARTER - r] : quarter_q15[r];
        return (quad >= 2) ? -v : v;
    endfunction

    // range * sine / 2^15, rounded half away from zero, clipped to +-65535
    function automatic longint scaled_mm(input logic [15:0] range, input int s);
        int unsigned     mag_s;
        longint unsigned mag;
        longint unsigned r;
        mag_s = (s < 0) ? -s : s;
        mag   = range;
        mag   = mag * mag_s;
        r     = (mag + 64'd16384) >> 15;
        if (r > 64'd65535)
            r = 64'd65535;
        return (s < 0) ? -longint'(r) : longint'(r);
    endfunction

    task automatic predict_point(input logic [15:0] range, input logic first);
        longint trim;
        longint lo_edge;
        longint hi_edge;
        longint nxt;
        longint px;
        longint py;
        longint dx;
        longint dy;
        longint lim;
        logic [SINE_BITS-1:0] sidx;
        logic [SINE_BITS-1:0] cidx;
        bit keep;
        point_t pt;
        if (first)
        begin
            beam_pos   = win_start;
            last_valid = 1'b0;
        end
        trim    = trim_on ? TRIM_UNITS : 0;
        lo_edge = longint'(win_start) + trim;
        hi_edge = longint'(win_end) - trim;
        if (range >= lim_lo && range <= lim_hi && beam_pos > lo_edge && beam_pos < hi_edge)
        begin
            sidx = beam_pos[15:16-SINE_BITS];
            cidx = sidx + SINE_BITS'(QUARTER);
            px   = scaled_mm(range, sine_q15(cidx));
            py   = scaled_mm(range, sine_q15(sidx));
            keep = 1'b1;
            if (last_valid)
            begin
                dx   = px - last_x;
                dy   = py - last_y;
                lim  = gap_mm;
                keep = (dx * dx + dy * dy) <= lim * lim;
            end
            if (keep)
            begin
                pt.x = px[16:0];
                pt.y = py[16:0];
                pending_points.insert(pending_points.size(), pt);
            end
            last_x     = px[16:0];
            last_y     = py[16:0];
            last_valid = 1'b1;
        end
        nxt = beam_pos + longint'(beam_step);
        if (nxt > BEAM_POS_HI)
            nxt = BEAM_POS_HI;
        if (nxt < BEAM_POS_LO)
            nxt = BEAM_POS_LO;
        beam_pos = nxt;
    endtask

    task automatic send_sample(input logic [15:0] range, input logic first);
        int gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= range;
        s_tuser  <= first;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_point(range, first);
        phase_items++;
    endtask

    // drop valid, wait for every predicted point, then let the sequencer finish
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_W-1:0] index, input logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_RANGE_MIN:   lim_lo    = data;
            CFG_RANGE_MAX:   lim_hi    = data;
            CFG_ANGLE_START: win_start = data;
            CFG_ANGLE_END:   win_end   = data;
            CFG_ANGLE_STEP:  beam_step = data[13:0];
            CFG_TRUNCATE:    trim_on   = data[0];
            CFG_GAP_LIMIT:   gap_mm    = data;
            default:         ;
        endcase
    endtask

    // unused bits of the step and truncate writes carry random junk
    task automatic load_settings(input int lo, input int hi, input int start, input int stop,
                                 input int step, input int trim, input int gap);
        logic [15:0] junk;
        set_reg(CFG_RANGE_MIN, 16'(lo));
        set_reg(CFG_RANGE_MAX, 16'(hi));
        set_reg(CFG_ANGLE_START, 16'(start));
        set_reg(CFG_ANGLE_END, 16'(stop));
        junk       = 16'($urandom_range(0, 65535));
        junk[13:0] = 14'(step);
        set_reg(CFG_ANGLE_STEP, junk);
        junk    = 16'($urandom_range(0, 65535));
        junk[0] = 1'(trim);
        set_reg(CFG_TRUNCATE, junk);
        set_reg(CFG_GAP_LIMIT, 16'(gap));
    endtask

    task automatic run_scan(input int len, input int lo, input int hi, input int jump);
        int cur;
        int k;
        bit marked;
        cur    = int'($urandom_range(lo, hi));
        marked = ($urandom_range(0, 9) != 0);
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_sample(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            else
            begin
                cur = cur + int'($urandom_range(0, 2 * jump)) - jump;
                if (cur < 0)
                    cur = 0;
                if (cur > 65535)
                    cur = 65535;
                send_sample(16'(cur), (k == 0) && marked);
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_sample(16'd5000, 1'b1);
        send_sample(16'd5000, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd65535, 1'b0);
        send_sample(16'd10000, 1'b0);
        send_sample(16'd10001, 1'b0);
    endtask

    task automatic test_range_and_angle_extremes();
        int k;
        settle();
        load_settings(0, 65535, -32768, 32767, 4096, 0, 65535);
        send_sample(16'd65535, 1'b1);
        for (k = 0; k < 5; k++)
            send_sample(16'd65535, 1'b0);
    endtask

    task automatic test_truncated_window();
        settle();
        load_settings(0, 65535, -16384, 16384, 2731, 1, 65535);
        send_sample(16'd1000, 1'b1);
        send_sample(16'd1000, 1'b0);
        send_sample(16'd1000, 1'b0);
        settle();
        // beams land exactly on both narrowed edges
        set_reg(CFG_ANGLE_START, 16'd8191);
        send_sample(16'd1000, 1'b1);
        send_sample(16'd1000, 1'b0);
        send_sample(16'd1000, 1'b0);
    endtask

    task automatic test_closed_window();
        settle();
        load_settings(5000, 4000, -16384, 16384, 182, 0, 100);
        send_sample(16'd4500, 1'b1);
        send_sample(16'd4500, 1'b0);
        settle();
        load_settings(0, 65535, 100, 100, 1, 0, 100);
        send_sample(16'd4500, 1'b1);
        send_sample(16'd4500, 1'b0);
    endtask

    task automatic test_register_quirks();
        settle();
        load_settings(0, 65535, -16384, 16384, 182, 0, 100);
        set_reg(CFG_SPARE, 16'hFFFF);
        send_sample(16'd3000, 1'b1);
        send_sample(16'd3000, 1'b0);
        send_sample(16'd3000, 1'b0);
        settle();
        // new start applies to the window only, beam keeps its position
        set_reg(CFG_ANGLE_START, 16'(-20000));
        send_sample(16'd3000, 1'b0);
        send_sample(16'd3000, 1'b0);
    endtask

    task automatic test_random_scans();
        int phase;
        int quota;
        int lo;
        int hi;
        int st;
        int en;
        int sp;
        int gp;
        int jump;
        for (phase = 0; phase < 12; phase++)
        begin
            settle();
            gaps_on   = (phase % 3 != 2);
            stalls_on = (phase % 4 != 3);
            if (phase == 0)
                load_settings(0, 65535, -32768, 32767, 4096, 1, 65535);
            else if (phase == 1)
                load_settings(65535, 0, 32767, -32768, -4096, 0, 0);
            else
            begin
                lo = $urandom_range(0, 3000);
                hi = lo + int'($urandom_range(500, 20000));
                if ($urandom_range(0, 7) == 0)
                    hi = 65535;
                st = int'($urandom_range(0, 49152)) - 32768;
                en = st + int'($urandom_range(2000, 49152));
                if (en > 32767)
                    en = 32767;
                if ($urandom_range(0, 3) == 0)
                    sp = int'($urandom_range(0, 8192)) - 4096;
                else
                    sp = $urandom_range(20, 1200);
                case ($urandom_range(0, 9))
                    0:       gp = 65535;
                    1:       gp = 0;
                    default: gp = $urandom_range(1, 3000);
                endcase
                load_settings(lo, hi, st, en, sp, $urandom_range(0, 1), gp);
            end
            if ($urandom_range(0, 2) == 0)
                set_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
            if (lim_lo <= lim_hi)
            begin
                lo = lim_lo;
                hi = lim_hi;
            end
            else
            begin
                lo = 0;
                hi = 65535;
            end
            jump        = $urandom_range(5, 200);
            quota       = (phase == 1) ? 40 : 130;
            phase_items = 0;
            while (phase_items < quota)
            begin
                run_scan($urandom_range(3, 60), lo, hi, jump);
                if ($urandom_range(0, 9) == 0)
                    settle();
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            m_tready <= 1'b0;
            ready_hold--;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_points
        point_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            ready_hold = stalls_on ? $urandom_range(0, 7) : 0;
            if (pending_points.size() == 0)
            begin
                $error("unexpected point transaction: point_x %0d, point_y %0d",
                       $signed(m_tdata[16:0]), $signed(m_tdata[33:17]));
                mismatch_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (m_tdata[16:0] !== want.x)
                begin
                    $error("point_x mismatch: expected %0d, actual %0d",
                           want.x, $signed(m_tdata[16:0]));
                    mismatch_count++;
                end
                if (m_tdata[33:17] !== want.y)
                begin
                    $error("point_y mismatch: expected %0d, actual %0d",
                           want.y, $signed(m_tdata[33:17]));
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_RANGE_MIN;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        beam_pos  = win_start;
        for (i = 0; i <= QUARTER; i++)
            quarter_q15[i] = quarter_wave_q15(i);
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_range_and_angle_extremes();
        test_truncated_window();
        test_closed_window();
        test_register_quirks();
        test_random_scans();
        settle();

        if (mismatch_count == 0 && pending_points.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== laser_scan_to_points_filter.f =====
rtl/core/lsp_pkg.sv
rtl/core/laser_scan_to_points_filter.sv
bench/tb_laser_scan_to_points_filter.sv
